>>> design/pgalloc_pkg.sv
// Shared types and constants for the page allocator with reference counts.
package pgalloc_pkg;

  localparam int ADDR_W          = 32;
  localparam int REF_W           = 16;
  localparam int FUP_W           = 15;
  localparam int CFG_IDX_W       = 1;
  localparam int NUM_PAGES_DEF   = 32768;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REF_INC = 2'd2,
    OP_REF_GET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_BAD_ADDR = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_BASE   = 1'd0,
    CFG_FIRST_PAGE = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

>>> design/page_allocator_with_refcounts_top.sv
// Top level of the page frame allocator with per-page reference counts.
//
// Usage: an item (operation and page address) is taken at a rising edge where
// start is high and busy is low. Every item gives exactly one result, shown on
// out_status, out_alloc_addr and out_ref_count for one cycle with out_valid high.
// The receiver cannot stall; it must take the result in that cycle.
//
// Each item has an accept cycle and an execute cycle: in the accept cycle the count
// table and the free stack are read at the addresses derived from the item, in the
// following cycle the fetched data is modified and written back and the result is
// registered. The result appears in the cycle after that, while busy is already
// low, so a new item can be accepted while the last result is shown. No item is
// taken while one executes, as each memory is written in the execute cycle.
//
// After reset the block sweeps the count table to zero, one entry a cycle, over all
// NUM_PAGES entries with busy high. Configuration writes (mem_base and
// first_usable_page) through the cfg_ channel must come while no item is in
// flight; the block does not enforce it. Frees fill the initially empty free stack.
module page_allocator_with_refcounts_top #(
  parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES = pgalloc_pkg::PAGE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic [pgalloc_pkg::ADDR_W-1:0]      in_page_addr,
  // result channel
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [pgalloc_pkg::ADDR_W-1:0]      out_alloc_addr,
  output logic [pgalloc_pkg::REF_W-1:0]       out_ref_count,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgalloc_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int ADDR_W  = pgalloc_pkg::ADDR_W;
  localparam int REF_W   = pgalloc_pkg::REF_W;
  localparam int FUP_W   = pgalloc_pkg::FUP_W;
  localparam int IDX_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int TOP_W   = $clog2(NUM_PAGES + 1);
  localparam int PB_BITS = $clog2(PAGE_BYTES);
  localparam int Q_W     = ADDR_W - PB_BITS;
  localparam int CMP_W   = ADDR_W + 1;

  localparam logic [CMP_W-1:0] NUM_PAGES_C  = CMP_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(NUM_PAGES - 1);
  localparam logic [TOP_W-1:0] STACK_CAP    = TOP_W'(NUM_PAGES);

  // Configuration registers.
  logic [ADDR_W-1:0] mem_base_r;
  logic [FUP_W-1:0]  first_page_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_base_r   <= ADDR_W'(32'h8000_0000);
      first_page_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (pgalloc_pkg::cfg_reg_t'(cfg_index))
        pgalloc_pkg::CFG_MEM_BASE:   mem_base_r   <= cfg_data;
        pgalloc_pkg::CFG_FIRST_PAGE: first_page_r <= cfg_data[FUP_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and item registers.
  pgalloc_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [TOP_W-1:0]    free_top_r, free_top_nxt;
  pgalloc_pkg::op_t    op_r;
  logic [IDX_W-1:0]    idx_r;
  logic                addr_ok_r;
  logic                empty_r;

  logic                out_valid_r, out_valid_nxt;
  pgalloc_pkg::status_t out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_alloc_addr_r, out_alloc_addr_nxt;
  logic [REF_W-1:0]    out_ref_count_r, out_ref_count_nxt;

  // Memories: count table and free stack, one write and one registered read each.
  logic [REF_W-1:0] ref_table [NUM_PAGES];
  logic [IDX_W-1:0] free_stack [NUM_PAGES];

  logic             rt_we;
  logic [IDX_W-1:0] rt_waddr;
  logic [REF_W-1:0] rt_wdata;
  logic [IDX_W-1:0] rt_raddr;
  logic [REF_W-1:0] rt_rdata_r;

  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  logic [IDX_W-1:0] st_wdata;
  logic [IDX_W-1:0] st_raddr;
  logic [IDX_W-1:0] st_rdata_r;

  always_ff @(posedge clk) begin
    if (rt_we) begin
      ref_table[rt_waddr] <= rt_wdata;
    end
    rt_rdata_r <= ref_table[rt_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      free_stack[st_waddr] <= st_wdata;
    end
    st_rdata_r <= free_stack[st_raddr];
  end

  // Address decode of the incoming item: offset from mem_base, page index,
  // alignment and range checks.
  logic              accept;
  logic [ADDR_W-1:0] offset;
  logic [Q_W-1:0]    page_q;
  logic [CMP_W-1:0]  page_q_x;
  logic              below_base;
  logic              aligned;
  logic              in_range;
  logic              above_first;
  logic              in_addr_ok;
  logic [TOP_W-1:0]  pop_ptr;

  assign accept      = start && !busy;
  assign below_base  = in_page_addr < mem_base_r;
  assign offset      = in_page_addr - mem_base_r;
  assign page_q      = offset[ADDR_W-1:PB_BITS];
  assign page_q_x    = CMP_W'(page_q);
  assign aligned     = (offset[PB_BITS-1:0] == '0);
  assign in_range    = page_q_x < NUM_PAGES_C;
  assign above_first = page_q_x >= CMP_W'(first_page_r);
  assign pop_ptr     = free_top_r - TOP_W'(1);

  always_comb begin
    if (pgalloc_pkg::op_t'(in_operation) == pgalloc_pkg::OP_FREE) begin
      in_addr_ok = !below_base && aligned && in_range && above_first;
    end else begin
      in_addr_ok = !below_base && in_range;
    end
  end

  assign rt_raddr = page_q_x[IDX_W-1:0];
  assign st_raddr = pop_ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= pgalloc_pkg::op_t'(in_operation);
      idx_r     <= page_q_x[IDX_W-1:0];
      addr_ok_r <= in_addr_ok;
      empty_r   <= (free_top_r == '0);
    end
  end

  // Next-state logic: reset clear sweep, accept, and read-modify-write of the fetched entries in the execute cycle.
  always_comb begin
    state_nxt          = state_r;
    clr_nxt            = clr_r;
    free_top_nxt       = free_top_r;
    rt_we              = 1'b0;
    rt_waddr           = idx_r;
    rt_wdata           = '0;
    st_we              = 1'b0;
    st_waddr           = free_top_r[IDX_W-1:0];
    st_wdata           = idx_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = pgalloc_pkg::STAT_OK;
    out_alloc_addr_nxt = '0;
    out_ref_count_nxt  = '0;

    case (state_r)
      pgalloc_pkg::S_CLEAR: begin
        rt_we    = 1'b1;
        rt_waddr = clr_r;
        rt_wdata = '0;
        clr_nxt  = clr_r + IDX_W'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = pgalloc_pkg::S_IDLE;
        end
      end
      pgalloc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = pgalloc_pkg::S_EXEC;
        end
      end
      pgalloc_pkg::S_EXEC: begin
        state_nxt     = pgalloc_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        case (op_r)
          pgalloc_pkg::OP_ALLOC: begin
            if (empty_r) begin
              out_status_nxt = pgalloc_pkg::STAT_EMPTY;
            end else begin
              free_top_nxt       = pop_ptr;
              rt_we              = 1'b1;
              rt_waddr           = st_rdata_r;
              rt_wdata           = REF_W'(1);
              out_ref_count_nxt  = REF_W'(1);
              out_alloc_addr_nxt = mem_base_r + (ADDR_W'(st_rdata_r) << PB_BITS);
            end
          end
          pgalloc_pkg::OP_FREE: begin
            if (!addr_ok_r) begin
              out_status_nxt = pgalloc_pkg::STAT_BAD_ADDR;
            end else if (rt_rdata_r > REF_W'(1)) begin
              rt_we             = 1'b1;
              rt_wdata          = rt_rdata_r - REF_W'(1);
              out_ref_count_nxt = rt_rdata_r - REF_W'(1);
            end else begin
              rt_we    = 1'b1;
              rt_wdata = '0;
              if (free_top_r >= STACK_CAP) begin
                out_status_nxt = pgalloc_pkg::STAT_FULL;
              end else begin
                st_we        = 1'b1;
                free_top_nxt = free_top_r + TOP_W'(1);
              end
            end
          end
          pgalloc_pkg::OP_REF_INC: begin
            if (!addr_ok_r) begin
              out_status_nxt = pgalloc_pkg::STAT_BAD_ADDR;
            end else if (rt_rdata_r != pgalloc_pkg::REF_MAX) begin
              rt_we             = 1'b1;
              rt_wdata          = rt_rdata_r + REF_W'(1);
              out_ref_count_nxt = rt_rdata_r + REF_W'(1);
            end else begin
              out_ref_count_nxt = rt_rdata_r;
            end
          end
          pgalloc_pkg::OP_REF_GET: begin
            if (!addr_ok_r) begin
              out_status_nxt = pgalloc_pkg::STAT_BAD_ADDR;
            end else begin
              out_ref_count_nxt = rt_rdata_r;
            end
          end
          default: ;
        endcase
      end
      default: begin
        state_nxt = pgalloc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgalloc_pkg::S_CLEAR;
      clr_r       <= '0;
      free_top_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_top_r  <= free_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r     <= out_status_nxt;
    out_alloc_addr_r <= out_alloc_addr_nxt;
    out_ref_count_r  <= out_ref_count_nxt;
  end

  assign busy           = (state_r != pgalloc_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_addr = out_alloc_addr_r;
  assign out_ref_count  = out_ref_count_r;

endmodule
